// ----- hdl/amre_pkg.sv -----
package amre_pkg;

  // Input beat: one affine matrix
  typedef struct packed {
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] skew_0;
    logic signed [31:0] skew_1;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
  } matrix_t;

  // Output beat: one byte of the packed record
  typedef struct packed {
    logic [7:0] packed_byte;
    logic       last_byte;
  } record_t;

  localparam logic [31:0] ONE_FIXED   = 32'h0001_0000;
  localparam logic [4:0]  WIDTH_CLAMP = 5'd31;
  localparam int unsigned WIDTH_BITS  = 5;
  localparam int unsigned PC_W        = 4;
  localparam int unsigned ACC_W       = 40;
  localparam int unsigned CNT_W       = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = 6'd38;

  // Micro-operations of the datapath
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_FLAG  = 3'd1,
    OP_WIDTH = 3'd2,
    OP_VAL_A = 3'd3,
    OP_VAL_B = 3'd4
  } op_t;

  // Operand pair select
  typedef enum logic [1:0] {
    SEL_SCALE = 2'd0,
    SEL_ROT   = 2'd1,
    SEL_MOVE  = 2'd2
  } sel_t;

  // Jump conditions
  typedef enum logic [1:0] {
    JC_NONE = 2'd0,
    JC_SKIP = 2'd1,
    JC_ZERO = 2'd2
  } jc_t;

  typedef struct packed {
    op_t             op;
    sel_t            sel;
    jc_t             jc;
    logic [PC_W-1:0] target;
  } uword_t;

  localparam logic [PC_W-1:0] PC_START = 4'd0;
  localparam logic [PC_W-1:0] PC_ROT   = 4'd4;
  localparam logic [PC_W-1:0] PC_MOVE  = 4'd8;
  localparam logic [PC_W-1:0] PC_DONE  = 4'd11;

  // Control store: scale part, rotate part, translate part
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      4'd0:    w = '{op: OP_FLAG,  sel: SEL_SCALE, jc: JC_SKIP, target: PC_ROT};
      4'd1:    w = '{op: OP_WIDTH, sel: SEL_SCALE, jc: JC_NONE, target: PC_START};
      4'd2:    w = '{op: OP_VAL_A, sel: SEL_SCALE, jc: JC_NONE, target: PC_START};
      4'd3:    w = '{op: OP_VAL_B, sel: SEL_SCALE, jc: JC_NONE, target: PC_START};
      4'd4:    w = '{op: OP_FLAG,  sel: SEL_ROT,   jc: JC_SKIP, target: PC_MOVE};
      4'd5:    w = '{op: OP_WIDTH, sel: SEL_ROT,   jc: JC_NONE, target: PC_START};
      4'd6:    w = '{op: OP_VAL_A, sel: SEL_ROT,   jc: JC_NONE, target: PC_START};
      4'd7:    w = '{op: OP_VAL_B, sel: SEL_ROT,   jc: JC_NONE, target: PC_START};
      4'd8:    w = '{op: OP_WIDTH, sel: SEL_MOVE,  jc: JC_ZERO, target: PC_DONE};
      4'd9:    w = '{op: OP_VAL_A, sel: SEL_MOVE,  jc: JC_NONE, target: PC_START};
      4'd10:   w = '{op: OP_VAL_B, sel: SEL_MOVE,  jc: JC_NONE, target: PC_START};
      default: w = '{op: OP_NOP,   sel: SEL_MOVE,  jc: JC_NONE, target: PC_DONE};
    endcase
    return w;
  endfunction

  // Smallest two's-complement width of one value, 0 for zero
  function automatic logic [5:0] signed_width(input logic [31:0] u);
    logic [31:0] m;
    logic [5:0]  w;
    m = u[31] ? ~u : u;
    w = 6'd1;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) w = 6'(i + 2);
    end
    if (u == 32'd0) w = 6'd0;
    return w;
  endfunction

  // Width of a pair, clamped
  function automatic logic [4:0] pair_width(input logic [31:0] a, input logic [31:0] b);
    logic [5:0] wa;
    logic [5:0] wb;
    logic [5:0] w;
    wa = signed_width(a);
    wb = signed_width(b);
    w  = (wa > wb) ? wa : wb;
    return (w > {1'b0, WIDTH_CLAMP}) ? WIDTH_CLAMP : w[4:0];
  endfunction

endpackage

// ----- hdl/affine_matrix_record_encoder_unit.sv -----
// The microcode sequencer runs up to 11 field steps per matrix and the byte drain sends one
// byte per cycle while the output is not stalled, a step running in any cycle that leaves
// fewer than 8 bits buffered. The next matrix is taken the cycle after the last byte is
// loaded into the output register.
// Reset (rst, synchronous, active high) clears the sequencer, bit count and output valid.
module affine_matrix_record_encoder_unit #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               matrix_valid,
  output logic               matrix_stall,
  input  amre_pkg::matrix_t  matrix,
  output logic               record_valid,
  input  logic               record_stall,
  output amre_pkg::record_t  record
);

  localparam int unsigned SHIFT = 32 - VALUE_BITS;

  function automatic logic [31:0] sext(input logic [31:0] raw);
    logic signed [31:0] t;
    t = $signed(raw << SHIFT);
    return 32'(t >>> SHIFT);
  endfunction

  logic                             busy;
  logic [amre_pkg::PC_W-1:0]        pc;
  logic [amre_pkg::CNT_W-1:0]       cnt;
  logic [amre_pkg::ACC_W-1:0]       acc;
  logic [4:0]                       width;
  logic [31:0]                      sx, sy, r0, r1, tx, ty;

  amre_pkg::uword_t                 uw;
  logic [31:0]                      opa, opb;
  logic                             skip;
  logic [4:0]                       pw;
  logic                             done;
  logic                             take;
  logic                             byte_avail;
  logic                             emit;
  logic                             emit_last;
  logic [7:0]                       emit_byte;
  logic [amre_pkg::ACC_W+7:0]       drain;
  logic [amre_pkg::CNT_W-1:0]       cnt_after;
  logic                             step_go;
  logic [amre_pkg::CNT_W-1:0]       n;
  logic [31:0]                      bits;
  logic                             taken;
  logic [amre_pkg::PC_W-1:0]        pc_next;
  logic [amre_pkg::CNT_W-1:0]       cnt_next;

  assign matrix_stall = busy || rst;
  assign take         = matrix_valid && !matrix_stall;
  assign done         = (pc == amre_pkg::PC_DONE);
  assign uw           = amre_pkg::ucode(pc);

  // Select the operand pair for this step
  always_comb begin
    case (uw.sel)
      amre_pkg::SEL_SCALE: begin opa = sx; opb = sy; end
      amre_pkg::SEL_ROT:   begin opa = r0; opb = r1; end
      default:             begin opa = tx; opb = ty; end
    endcase
  end

  assign skip = (uw.sel == amre_pkg::SEL_SCALE)
              ? (opa == amre_pkg::ONE_FIXED && opb == amre_pkg::ONE_FIXED)
              : (opa == 32'd0 && opb == 32'd0);
  assign pw   = amre_pkg::pair_width(opa, opb);

  // Drain: oldest buffered bits on top, zero pad below
  assign drain      = {acc, 8'h00} >> cnt;
  assign emit_byte  = drain[7:0];
  assign byte_avail = busy && ((cnt >= 6'd8) || (done && cnt != '0));
  assign emit       = byte_avail && (!record_valid || !record_stall);
  assign emit_last  = done && (cnt <= 6'd8);
  assign cnt_after  = emit ? (emit_last ? '0 : cnt - 6'd8) : cnt;
  assign step_go    = busy && !done && (cnt_after < 6'd8);

  // Decode the control word into a bit field to append
  always_comb begin
    n     = '0;
    bits  = '0;
    taken = 1'b0;
    case (uw.op)
      amre_pkg::OP_FLAG: begin
        n     = 6'd1;
        bits  = {31'd0, ~skip};
        taken = (uw.jc == amre_pkg::JC_SKIP) && skip;
      end
      amre_pkg::OP_WIDTH: begin
        n     = 6'(amre_pkg::WIDTH_BITS);
        bits  = {27'd0, pw};
        taken = (uw.jc == amre_pkg::JC_ZERO) && (pw == 5'd0);
      end
      amre_pkg::OP_VAL_A: begin
        n    = {1'b0, width};
        bits = opa & ~(32'hFFFF_FFFF << width);
      end
      amre_pkg::OP_VAL_B: begin
        n    = {1'b0, width};
        bits = opb & ~(32'hFFFF_FFFF << width);
      end
      default: begin
        n = '0;
      end
    endcase
  end

  assign pc_next  = taken ? uw.target : pc + 4'd1;
  assign cnt_next = step_go ? cnt_after + n : cnt_after;

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= amre_pkg::PC_START;
      cnt  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      pc   <= amre_pkg::PC_START;
      cnt  <= '0;
    end else begin
      cnt <= cnt_next;
      if (step_go) pc <= pc_next;
      if (emit && emit_last) busy <= 1'b0;
    end
  end

  // Operand registers, width register and bit accumulator
  always_ff @(posedge clk) begin
    if (take) begin
      sx <= sext(matrix.scale_x);
      sy <= sext(matrix.scale_y);
      r0 <= sext(matrix.skew_0);
      r1 <= sext(matrix.skew_1);
      tx <= sext(matrix.move_x);
      ty <= sext(matrix.move_y);
    end
    if (step_go) begin
      acc <= (acc << n) | {8'd0, bits};
      if (uw.op == amre_pkg::OP_WIDTH) width <= pw;
    end
  end

  // Output register: load a byte, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      record_valid <= 1'b0;
    end else if (emit) begin
      record_valid <= 1'b1;
    end else if (!record_stall) begin
      record_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      record.packed_byte <= emit_byte;
      record.last_byte   <= emit_last;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= amre_pkg::CNT_MAX)
    else $error("bit buffer overfilled");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst) !busy |-> cnt == '0)
    else $error("bits left over when idle");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    emit && emit_last |=> !busy && record_valid && record.last_byte)
    else $error("last byte did not end the record");

  a_start: assert property (@(posedge clk) disable iff (rst)
    take |=> busy && pc == amre_pkg::PC_START && cnt == '0)
    else $error("record did not start at the first step");

endmodule

// ----- tb/affine_matrix_record_encoder_unit_test.sv -----
`timescale 1ns / 1ps

module affine_matrix_record_encoder_unit_test;

  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned REC_BITS    = 208;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 25;
  localparam logic [31:0] UNITY       = amre_pkg::ONE_FIXED;

  // Expected record bytes, worked out per accepted matrix
  class record_scoreboard;
    amre_pkg::record_t expected_bytes[$];
    int unsigned errors;
    int unsigned matrices;
    int unsigned bytes_checked;
    int unsigned with_scale;
    int unsigned with_rotate;
    logic [REC_BITS-1:0] bitbuf;
    int unsigned nbits;

    task report(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", what);
    endtask

    // Keep the low VALUE_BITS bits, sign-extended
    function logic [31:0] narrow(logic [31:0] raw);
      logic signed [31:0] s;
      s = raw << (32 - VALUE_BITS);
      s = s >>> (32 - VALUE_BITS);
      return s;
    endfunction

    // Smallest two's-complement width; zero needs none
    function int unsigned min_width(logic [31:0] v);
      logic [31:0] m;
      int unsigned w;
      if (v == 32'd0) return 0;
      m = v[31] ? ~v : v;
      w = 1;
      for (int i = 31; i >= 0; i--) begin
        if (m[i]) begin
          w = i + 2;
          break;
        end
      end
      return w;
    endfunction

    function void append(logic [31:0] v, int unsigned n);
      for (int i = int'(n) - 1; i >= 0; i--) begin
        bitbuf[REC_BITS - 1 - nbits] = v[i];
        nbits++;
      end
    endfunction

    function void append_pair(logic [31:0] a, logic [31:0] b);
      int unsigned w;
      int unsigned wb;
      w  = min_width(a);
      wb = min_width(b);
      if (wb > w) w = wb;
      if (w > amre_pkg::WIDTH_CLAMP) w = amre_pkg::WIDTH_CLAMP;
      append(w, amre_pkg::WIDTH_BITS);
      append(a, w);
      append(b, w);
    endfunction

    // Build the record for one accepted matrix and queue its bytes
    function void note_matrix(amre_pkg::matrix_t m);
      logic [31:0] sx, sy, r0, r1, tx, ty;
      amre_pkg::record_t r;
      int unsigned nbytes;
      sx = narrow(m.scale_x);
      sy = narrow(m.scale_y);
      r0 = narrow(m.skew_0);
      r1 = narrow(m.skew_1);
      tx = narrow(m.move_x);
      ty = narrow(m.move_y);
      bitbuf = '0;
      nbits = 0;
      matrices++;
      if (sx == amre_pkg::ONE_FIXED && sy == amre_pkg::ONE_FIXED) begin
        append(32'd0, 1);
      end else begin
        with_scale++;
        append(32'd1, 1);
        append_pair(sx, sy);
      end
      if (r0 == 32'd0 && r1 == 32'd0) begin
        append(32'd0, 1);
      end else begin
        with_rotate++;
        append(32'd1, 1);
        append_pair(r0, r1);
      end
      append_pair(tx, ty);
      nbytes = (nbits + 7) / 8;
      for (int k = 0; k < int'(nbytes); k++) begin
        r.packed_byte = bitbuf[REC_BITS - 1 - 8 * k -: 8];
        r.last_byte   = (k == int'(nbytes) - 1);
        expected_bytes.push_back(r);
      end
    endfunction

    // Compare one output beat with the oldest expected byte
    task check_byte(amre_pkg::record_t got);
      amre_pkg::record_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h last=%0b", got.packed_byte, got.last_byte));
        return;
      end
      want = expected_bytes.pop_front();
      bytes_checked++;
      if (got.packed_byte !== want.packed_byte)
        report($sformatf("byte %0d: packed_byte %02h, want %02h",
                         bytes_checked, got.packed_byte, want.packed_byte));
      if (got.last_byte !== want.last_byte)
        report($sformatf("byte %0d: last_byte %0b, want %0b",
                         bytes_checked, got.last_byte, want.last_byte));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              matrix_valid = 1'b0;
  logic              matrix_stall;
  amre_pkg::matrix_t matrix = '0;
  logic              record_valid;
  logic              record_stall = 1'b0;
  amre_pkg::record_t record;

  record_scoreboard sb;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;
  amre_pkg::matrix_t directed[$];

  wire in_beat  = matrix_valid && !matrix_stall;
  wire out_beat = record_valid && !record_stall && !rst;

  affine_matrix_record_encoder_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .matrix_valid (matrix_valid),
    .matrix_stall (matrix_stall),
    .matrix       (matrix),
    .record_valid (record_valid),
    .record_stall (record_stall),
    .record       (record)
  );

  always #2 clk = ~clk;

  // Receiver: check each beat, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (out_beat) sb.check_byte(record);
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      record_stall <= 1'b1;
      hold_left--;
    end else begin
      record_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: stop when no beat moves for too long
  always @(posedge clk) begin
    if (in_beat || out_beat) begin
      idle_cycles = 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL affine_matrix_record_encoder_unit");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  // Narrow values of random width, with full-range ones, zero, the corner values and near-unity ones mixed in
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    logic signed [31:0] s;
    int unsigned w;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1, 2: begin
        w = $urandom_range(1, 31);
        s = $urandom << (32 - w);
        v = s >>> (32 - w);
      end
      3: v = '0;
      4: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
      default: v = UNITY + 32'($urandom_range(0, 4)) - 32'd2;
    endcase
    return v;
  endfunction

  function automatic amre_pkg::matrix_t random_matrix();
    amre_pkg::matrix_t m;
    m.scale_x = pick_value();
    m.scale_y = pick_value();
    m.skew_0  = pick_value();
    m.skew_1  = pick_value();
    m.move_x  = pick_value();
    m.move_y  = pick_value();
    // Skip the scale part often, and sometimes only half match
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        m.scale_x = UNITY;
        m.scale_y = UNITY;
      end
      3: if ($urandom_range(0, 1)) m.scale_x = UNITY; else m.scale_y = UNITY;
      default: ;
    endcase
    // Likewise for the rotate part
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        m.skew_0 = '0;
        m.skew_1 = '0;
      end
      3: if ($urandom_range(0, 1)) m.skew_0 = '0; else m.skew_1 = '0;
      default: ;
    endcase
    return m;
  endfunction

  // Offer one matrix, idling first at random; hold it until accepted
  task automatic send_matrix(input amre_pkg::matrix_t m);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      matrix_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    matrix       <= m;
    matrix_valid <= 1'b1;
    do @(posedge clk); while (matrix_stall);
    sb.note_matrix(m);
  endtask

  // Stop offering and wait for every expected byte
  task automatic drain_records();
    matrix_valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    directed.push_back(amre_pkg::matrix_t'{UNITY, UNITY, 32'd0, 32'd0, 32'd0, 32'd0});
    directed.push_back(amre_pkg::matrix_t'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    directed.push_back(amre_pkg::matrix_t'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    directed.push_back(amre_pkg::matrix_t'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    directed.push_back(amre_pkg::matrix_t'{32'h3FFF_FFFF, 32'hC000_0000, 32'h3FFF_FFFF,
                                           32'hC000_0000, 32'h3FFF_FFFF, 32'hC000_0000});
    directed.push_back(amre_pkg::matrix_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    directed.push_back(amre_pkg::matrix_t'{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1});
    directed.push_back(amre_pkg::matrix_t'{UNITY, 32'h0002_0000, 32'd0, 32'd0,
                                           32'd3, 32'd0});
    directed.push_back(amre_pkg::matrix_t'{32'd0, UNITY, 32'd0, 32'd0,
                                           32'd0, 32'hFFFF_FFF0});
    directed.push_back(amre_pkg::matrix_t'{UNITY, UNITY, 32'h0000_1234, 32'd0,
                                           32'd7, 32'd9});
    directed.push_back(amre_pkg::matrix_t'{UNITY, UNITY, 32'd0, 32'hFFFF_FFFF,
                                           32'd0, 32'd0});
    directed.push_back(amre_pkg::matrix_t'{UNITY, UNITY, 32'h8000_0000, 32'd1,
                                           32'd5, 32'hFFFF_FFFB});
    directed.push_back(amre_pkg::matrix_t'{UNITY, UNITY, 32'd0, 32'd0,
                                           32'h8000_0000, 32'd0});
    directed.push_back(amre_pkg::matrix_t'{UNITY, UNITY, 32'd0, 32'd0,
                                           32'd0, 32'h7FFF_FFFF});
    directed.push_back(amre_pkg::matrix_t'{32'hFFFF_0000, 32'hFFFF_0000, 32'h0000_B505,
                                           32'hFFFF_4AFB, 32'd100, 32'hFFFF_FF38});
    directed.push_back(amre_pkg::matrix_t'{UNITY, 32'h0001_0001, 32'd0, 32'd0,
                                           32'd1, 32'd1});
    directed.push_back(amre_pkg::matrix_t'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                           32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
    directed.push_back(amre_pkg::matrix_t'{32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE,
                                           32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corner matrices, no idling
    foreach (directed[i]) send_matrix(directed[i]);
    drain_records();

    // Long receiver hold-off while the sender keeps offering
    hold_requests++;
    repeat (12) send_matrix(random_matrix());
    drain_records();

    // Random matrices under each idling mode
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      repeat (PHASE_ITEMS) send_matrix(random_matrix());
      drain_records();
    end

    // Let any stray bytes show up
    repeat (16) @(posedge clk);
    if (sb.expected_bytes.size() != 0)
      sb.report($sformatf("%0d expected bytes never arrived", sb.expected_bytes.size()));

    $display("Encoded %0d matrices (%0d with scale part, %0d with rotate part), %0d bytes checked",
             sb.matrices, sb.with_scale, sb.with_rotate, sb.bytes_checked);
    $display("Idling: none, sender only, receiver only, both; one long receiver hold-off");
    if (sb.errors == 0) begin
      $display("PASS affine_matrix_record_encoder_unit");
    end else begin
      $display("FAIL affine_matrix_record_encoder_unit");
    end
    $finish;
  end

endmodule

// ----- affine_matrix_record_encoder_unit.f -----
hdl/amre_pkg.sv
hdl/affine_matrix_record_encoder_unit.sv
tb/affine_matrix_record_encoder_unit_test.sv
